// File: rtl/kuwa_pkg.sv
// Shared constants and types for the Kuwahara filter block.
package kuwa_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 4096;
    localparam int MAX_REGION = 8;

    localparam int PIX_W   = 8;
    localparam int FW_W    = 11;
    localparam int FH_W    = 13;
    localparam int RS_W    = 4;
    localparam int CFG_W   = 13;
    localparam int COL_W   = 10;
    localparam int ROW_W   = 12;
    localparam int POS_W   = 23;
    localparam int ADDR_W  = 14;
    localparam int DEPTH   = 2 * MAX_REGION * MAX_WIDTH;
    localparam int CNT_W   = 7;
    localparam int SUM_W   = 14;
    localparam int SSQ_W   = 22;
    localparam int NREG    = 4;

    typedef enum logic [1:0] {
        CFG_WIDTH  = 2'd0,
        CFG_HEIGHT = 2'd1,
        CFG_REGION = 2'd2,
        CFG_NONE   = 2'd3
    } cfg_idx_t;

    localparam logic OP_PIXEL = 1'b0;

endpackage

// File: rtl/kuwahara_filter.sv
// Top level of the Kuwahara filter: line store, window scan and region selection.
//
// Pixels enter on the s_axis channel in raster order, one item per pixel; tuser
// carries the op flag (0 for a pixel, 1 for a flush item) and tdata the gray value.
// Filtered pixels leave on the m_axis channel, with tlast high on the final pixel
// of a frame. An output pixel appears once (R-1) rows plus (R-1) pixels beyond it
// have been taken in; the last such outputs of a frame are drained by flush items.
// The frame size and region side R are written through the cfg port, by the user only
// while the block is idle, which the block itself does not enforce; a write to index 0, 1 or 2 restarts the frame.
//
// Each item is handled alone. An item that causes no output leaves the block idle.
// An item that causes an output keeps the input closed while its window is processed;
// N is the clipped window size, at most (2R-1)^2: the window is read from the line
// store one pixel per cycle over its single read port, then four passes (a 14-step
// serial division, the mean and the deviation term) and a four-way comparison follow.
// Reset clears all position counters and loads a 640 by 480 frame with R = 7; the
// line store needs no clearing since only pixels of the current frame are read.
// A finished pixel sits in an output register; the next item is still taken while
// it waits, and the block only pauses before loading the next result.
module kuwahara_filter (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] pixel
    input  logic        s_axis_tuser,   // [0] op
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] filtered
    output logic        m_axis_tlast,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [12:0] cfg_data
);

    typedef enum logic [3:0] {
        ST_IDLE, ST_SETUP, ST_SCAN, ST_DRAIN, ST_LOAD,
        ST_DIV, ST_NM, ST_QC, ST_CMP, ST_ROUND
    } state_t;

    localparam int PW = kuwa_pkg::PIX_W;
    localparam int AW = kuwa_pkg::ADDR_W;

    state_t state_reg;

    logic [kuwa_pkg::FW_W-1:0] fw_reg;
    logic [kuwa_pkg::FH_W-1:0] fh_reg;
    logic [kuwa_pkg::RS_W-1:0] rs_reg;

    logic [kuwa_pkg::POS_W-1:0] pin_reg, pout_reg;
    logic [kuwa_pkg::COL_W-1:0] ocol_reg;
    logic [kuwa_pkg::ROW_W-1:0] orow_reg;

    // Window bounds and scan position.
    logic [kuwa_pkg::ROW_W-1:0] hi_r_reg, r_reg;
    logic [kuwa_pkg::COL_W-1:0] lo_c_reg, hi_c_reg, c_reg;
    logic [AW-1:0]              addr_reg, rowbase_reg;

    logic [PW-1:0] mem [kuwa_pkg::DEPTH];
    logic [PW-1:0] rd_data_reg;
    logic          rd_valid_reg;
    logic [3:0]    rd_flag_reg;

    logic [kuwa_pkg::CNT_W-1:0] n_reg   [kuwa_pkg::NREG];
    logic [kuwa_pkg::SUM_W-1:0] s_reg   [kuwa_pkg::NREG];
    logic [kuwa_pkg::SSQ_W-1:0] ss_reg  [kuwa_pkg::NREG];
    logic [PW-1:0]              mean_reg[kuwa_pkg::NREG];
    logic [kuwa_pkg::CNT_W-1:0] rem_reg [kuwa_pkg::NREG];
    logic [kuwa_pkg::SSQ_W-1:0] dev_reg [kuwa_pkg::NREG];

    logic [1:0]                 k_reg;
    logic [3:0]                 step_reg;
    logic [kuwa_pkg::CNT_W-1:0] div_rem_reg;
    logic [kuwa_pkg::SUM_W-1:0] div_quo_reg;
    logic [kuwa_pkg::SUM_W-1:0] t_reg;

    logic [kuwa_pkg::CNT_W-1:0] best_n_reg;
    logic [kuwa_pkg::SSQ_W-1:0] best_dev_reg;
    logic [PW-1:0]              best_mean_reg;
    logic [kuwa_pkg::CNT_W-1:0] best_rem_reg;

    logic          out_valid_reg;
    logic [PW-1:0] out_data_reg;
    logic          out_last_reg;

    // Effective configuration, clamped to the supported ranges.
    logic [kuwa_pkg::FW_W-1:0] w_eff;
    logic [kuwa_pkg::FH_W-1:0] h_eff;
    logic [2:0]                pad;
    logic [kuwa_pkg::POS_W-1:0] total;
    logic [kuwa_pkg::POS_W-1:0] lag;

    always_comb
    begin
        if (fw_reg == '0)
            w_eff = kuwa_pkg::FW_W'(1);
        else if (fw_reg > kuwa_pkg::FW_W'(kuwa_pkg::MAX_WIDTH))
            w_eff = kuwa_pkg::FW_W'(kuwa_pkg::MAX_WIDTH);
        else
            w_eff = fw_reg;
        if (fh_reg == '0)
            h_eff = kuwa_pkg::FH_W'(1);
        else if (fh_reg > kuwa_pkg::FH_W'(kuwa_pkg::MAX_HEIGHT))
            h_eff = kuwa_pkg::FH_W'(kuwa_pkg::MAX_HEIGHT);
        else
            h_eff = fh_reg;
        if (rs_reg == '0)
            pad = 3'd0;
        else if (rs_reg > kuwa_pkg::RS_W'(kuwa_pkg::MAX_REGION))
            pad = 3'(kuwa_pkg::MAX_REGION - 1);
        else
            pad = 3'(rs_reg - 4'd1);
        total = kuwa_pkg::POS_W'(w_eff * h_eff);
        lag   = kuwa_pkg::POS_W'(pad * w_eff) + kuwa_pkg::POS_W'(pad);
    end

    // Input decisions.
    logic s_fire, do_write, do_emit;
    logic [kuwa_pkg::POS_W-1:0] pin_inc;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign s_fire   = s_axis_tvalid && s_axis_tready;
    assign pin_inc  = pin_reg + kuwa_pkg::POS_W'(1);
    assign do_write = s_fire && (s_axis_tuser == kuwa_pkg::OP_PIXEL) && (pin_reg < total);
    assign do_emit  = do_write ? ((pin_inc - pout_reg) > lag)
                               : (s_fire && (pin_reg >= total) && (pout_reg < total));

    // Window bounds of the next output pixel.
    logic [kuwa_pkg::ROW_W-1:0] lo_r, hi_r;
    logic [kuwa_pkg::COL_W-1:0] lo_c, hi_c;
    logic [kuwa_pkg::ROW_W:0]   y_hi;
    logic [kuwa_pkg::COL_W:0]   x_hi;
    logic [AW-1:0]              start_addr;

    always_comb
    begin
        lo_r = (orow_reg >= kuwa_pkg::ROW_W'(pad)) ? orow_reg - kuwa_pkg::ROW_W'(pad) : '0;
        lo_c = (ocol_reg >= kuwa_pkg::COL_W'(pad)) ? ocol_reg - kuwa_pkg::COL_W'(pad) : '0;
        y_hi = {1'b0, orow_reg} + (kuwa_pkg::ROW_W+1)'(pad);
        x_hi = {1'b0, ocol_reg} + (kuwa_pkg::COL_W+1)'(pad);
        hi_r = (kuwa_pkg::FH_W'(y_hi) < h_eff) ? y_hi[kuwa_pkg::ROW_W-1:0]
                                               : kuwa_pkg::ROW_W'(h_eff - 13'd1);
        hi_c = (kuwa_pkg::FW_W'(x_hi) < w_eff) ? x_hi[kuwa_pkg::COL_W-1:0]
                                               : kuwa_pkg::COL_W'(w_eff - 11'd1);
        start_addr = AW'(lo_r * w_eff) + AW'(lo_c);
    end

    // Line store: one write port for incoming pixels, one registered read port.
    always_ff @(posedge clk)
    begin
        if (do_write)
            mem[pin_reg[AW-1:0]] <= s_axis_tdata;
        if (state_reg == ST_SCAN)
            rd_data_reg <= mem[addr_reg];
    end

    // Divider step, deviation term and comparison.
    logic [kuwa_pkg::CNT_W:0]   div_t;
    logic                       div_ge;
    logic [kuwa_pkg::SUM_W:0]   two_s_minus_t;
    logic [kuwa_pkg::SSQ_W:0]   dev_term;
    logic [28:0]                lhs, rhs;
    logic                       better;
    logic [PW:0]                rounded;
    logic [kuwa_pkg::CNT_W:0]   two_rem;
    logic [15:0]                sq;

    always_comb
    begin
        div_t  = {div_rem_reg, div_quo_reg[kuwa_pkg::SUM_W-1]};
        div_ge = div_t >= {1'b0, n_reg[k_reg]};
        two_s_minus_t = {s_reg[k_reg], 1'b0} - {1'b0, t_reg};
        dev_term = (kuwa_pkg::SSQ_W+1)'(mean_reg[k_reg] * two_s_minus_t);
        lhs = 29'(dev_reg[k_reg] * (best_n_reg - 7'd1));
        rhs = 29'(best_dev_reg * (n_reg[k_reg] - 7'd1));
        if (n_reg[k_reg] <= 7'd1)
            better = 1'b0;
        else if (best_n_reg <= 7'd1)
            better = 1'b1;
        else
            better = lhs < rhs;
        two_rem = {best_rem_reg, 1'b0};
        rounded = {1'b0, best_mean_reg};
        if ((two_rem > {1'b0, best_n_reg}) ||
            ((two_rem == {1'b0, best_n_reg}) && best_mean_reg[0]))
            rounded = rounded + 9'd1;
        sq = rd_data_reg * rd_data_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            fw_reg        <= kuwa_pkg::FW_W'(640);
            fh_reg        <= kuwa_pkg::FH_W'(480);
            rs_reg        <= kuwa_pkg::RS_W'(7);
            pin_reg       <= '0;
            pout_reg      <= '0;
            ocol_reg      <= '0;
            orow_reg      <= '0;
            rd_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            k_reg         <= '0;
            step_reg      <= '0;
        end
        else
        begin
            rd_valid_reg <= (state_reg == ST_SCAN);
            // While a new result is loaded the output valid is handled below.
            if (out_valid_reg && m_axis_tready && (state_reg != ST_ROUND))
                out_valid_reg <= 1'b0;

            if (cfg_we && (cfg_index != kuwa_pkg::CFG_NONE))
            begin
                unique case (cfg_index)
                    kuwa_pkg::CFG_WIDTH:  fw_reg <= cfg_data[kuwa_pkg::FW_W-1:0];
                    kuwa_pkg::CFG_HEIGHT: fh_reg <= cfg_data;
                    kuwa_pkg::CFG_REGION: rs_reg <= cfg_data[kuwa_pkg::RS_W-1:0];
                    default: ;
                endcase
                pin_reg  <= '0;
                pout_reg <= '0;
                ocol_reg <= '0;
                orow_reg <= '0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (do_write)
                        pin_reg <= pin_inc;
                    if (do_emit)
                        state_reg <= ST_SETUP;
                end
                ST_SETUP:
                begin
                    state_reg <= ST_SCAN;
                end
                ST_SCAN:
                begin
                    if (c_reg == hi_c_reg)
                    begin
                        if (r_reg == hi_r_reg)
                            state_reg <= ST_DRAIN;
                    end
                end
                ST_DRAIN:
                begin
                    k_reg     <= '0;
                    state_reg <= ST_LOAD;
                end
                ST_LOAD:
                begin
                    step_reg  <= '0;
                    state_reg <= ST_DIV;
                end
                ST_DIV:
                begin
                    step_reg <= step_reg + 4'd1;
                    if (step_reg == 4'(kuwa_pkg::SUM_W - 1))
                        state_reg <= ST_NM;
                end
                ST_NM:
                begin
                    state_reg <= ST_QC;
                end
                ST_QC:
                begin
                    k_reg     <= k_reg + 2'd1;
                    state_reg <= (k_reg == 2'd3) ? ST_CMP : ST_LOAD;
                end
                ST_CMP:
                begin
                    k_reg <= k_reg + 2'd1;
                    if (k_reg == 2'd3)
                        state_reg <= ST_ROUND;
                end
                ST_ROUND:
                begin
                    if (!out_valid_reg || m_axis_tready)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= ST_IDLE;
                        if (pout_reg + kuwa_pkg::POS_W'(1) == total)
                        begin
                            pin_reg  <= '0;
                            pout_reg <= '0;
                            ocol_reg <= '0;
                            orow_reg <= '0;
                        end
                        else
                        begin
                            pout_reg <= pout_reg + kuwa_pkg::POS_W'(1);
                            if (kuwa_pkg::FW_W'(ocol_reg) + 11'd1 >= w_eff)
                            begin
                                ocol_reg <= '0;
                                orow_reg <= orow_reg + kuwa_pkg::ROW_W'(1);
                            end
                            else
                                ocol_reg <= ocol_reg + kuwa_pkg::COL_W'(1);
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_SETUP)
        begin
            hi_r_reg    <= hi_r;
            lo_c_reg    <= lo_c;
            hi_c_reg    <= hi_c;
            r_reg       <= lo_r;
            c_reg       <= lo_c;
            addr_reg    <= start_addr;
            rowbase_reg <= start_addr;
            for (int j = 0; j < kuwa_pkg::NREG; j++)
            begin
                n_reg[j]  <= '0;
                s_reg[j]  <= '0;
                ss_reg[j] <= '0;
            end
        end

        if (state_reg == ST_SCAN)
        begin
            // Region 0 bottom-right, 1 top-left, 2 top-right, 3 bottom-left.
            rd_flag_reg[0] <= (r_reg >= orow_reg) && (c_reg >= ocol_reg);
            rd_flag_reg[1] <= (r_reg <= orow_reg) && (c_reg <= ocol_reg);
            rd_flag_reg[2] <= (r_reg <= orow_reg) && (c_reg >= ocol_reg);
            rd_flag_reg[3] <= (r_reg >= orow_reg) && (c_reg <= ocol_reg);
            if (c_reg == hi_c_reg)
            begin
                r_reg       <= r_reg + kuwa_pkg::ROW_W'(1);
                c_reg       <= lo_c_reg;
                rowbase_reg <= rowbase_reg + AW'(w_eff);
                addr_reg    <= rowbase_reg + AW'(w_eff);
            end
            else
            begin
                c_reg    <= c_reg + kuwa_pkg::COL_W'(1);
                addr_reg <= addr_reg + AW'(1);
            end
        end

        if (rd_valid_reg)
        begin
            for (int j = 0; j < kuwa_pkg::NREG; j++)
            begin
                if (rd_flag_reg[j])
                begin
                    n_reg[j]  <= n_reg[j] + 7'd1;
                    s_reg[j]  <= s_reg[j] + kuwa_pkg::SUM_W'(rd_data_reg);
                    ss_reg[j] <= ss_reg[j] + kuwa_pkg::SSQ_W'(sq);
                end
            end
        end

        case (state_reg)
            ST_LOAD:
            begin
                div_quo_reg <= s_reg[k_reg];
                div_rem_reg <= '0;
            end
            ST_DIV:
            begin
                div_rem_reg <= div_ge ? kuwa_pkg::CNT_W'(div_t - {1'b0, n_reg[k_reg]})
                                      : div_t[kuwa_pkg::CNT_W-1:0];
                div_quo_reg <= {div_quo_reg[kuwa_pkg::SUM_W-2:0], div_ge};
            end
            ST_NM:
            begin
                mean_reg[k_reg] <= div_quo_reg[PW-1:0];
                rem_reg[k_reg]  <= div_rem_reg;
                t_reg           <= kuwa_pkg::SUM_W'(n_reg[k_reg] * div_quo_reg[PW-1:0]);
            end
            ST_QC:
            begin
                dev_reg[k_reg] <= kuwa_pkg::SSQ_W'({1'b0, ss_reg[k_reg]} - dev_term);
            end
            ST_CMP:
            begin
                if ((k_reg == 2'd0) || better)
                begin
                    best_n_reg    <= n_reg[k_reg];
                    best_dev_reg  <= dev_reg[k_reg];
                    best_mean_reg <= mean_reg[k_reg];
                    best_rem_reg  <= rem_reg[k_reg];
                end
            end
            ST_ROUND:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_data_reg <= rounded[PW] ? {PW{1'b1}} : rounded[PW-1:0];
                    out_last_reg <= (pout_reg + kuwa_pkg::POS_W'(1) == total);
                end
            end
            default: ;
        endcase
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tlast  = out_last_reg;

endmodule
